@@ rtl/core/rsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants for the ray / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int RSI_FRAC_BITS = 16;
    localparam int RSI_SQ_STEPS  = 66;
    localparam int RSI_DIV_STEPS = 32;

    localparam logic [31:0] RSI_DIST_MIN = 32'h8000_0000;
    localparam logic [31:0] RSI_DIST_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] sphere_radius;
    } t_ray_in;

    typedef struct packed {
        logic               hit;
        logic               degenerate;
        logic signed [31:0] distance;
    } t_ray_out;

endpackage

@@ rtl/core/ray_sphere_intersect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Fully pipelined ray / sphere test: quadratic setup, exact wide discriminant,
// digit-serial square root and restoring divide, one stage per digit.
// ----------------------------------------------------------------------------
// Accepts one ray/sphere pair per clock unless stalled and returns one result
// per pair, in order. It has 8 setup stages (differences, 33x33 products,
// sums, magnitudes, 33-bit partial products of the 132-bit discriminant), 66
// square-root stages (one root bit each), 3 stages forming the numerator and
// overflow check, 32 divide stages (one quotient bit each) and the output
// register. A stall on the output freezes the whole pipeline in place; the
// input stall is asserted exactly while a result is held and stalled.
module ray_sphere_intersect #(
    parameter int FRAC_BITS = rsi_pkg::RSI_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rsi_pkg::t_ray_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rsi_pkg::t_ray_out o_out_data
);
    import rsi_pkg::*;

    localparam int NW = 67 + FRAC_BITS;
    localparam int CW = (NW + 1 > 97) ? NW + 1 : 97;

    typedef struct packed {
        logic               azero;
        logic               dneg;
        logic        [63:0] a;
        logic signed [66:0] hb;
    } t_tag;

    typedef struct packed {
        logic        azero;
        logic        dneg;
        logic        neg;
        logic        over;
        logic [63:0] a;
    } t_dtag;

    logic w_en;
    logic r_out_valid;
    t_ray_out r_out;

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // stage 1: differences
    logic               r1_v;
    logic signed [32:0] r1_oc  [3];
    logic signed [31:0] r1_dir [3];
    logic        [30:0] r1_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_oc[0]  <= $signed({i_in_data.origin_x[31], i_in_data.origin_x})
                       - $signed({i_in_data.center_x[31], i_in_data.center_x});
            r1_oc[1]  <= $signed({i_in_data.origin_y[31], i_in_data.origin_y})
                       - $signed({i_in_data.center_y[31], i_in_data.center_y});
            r1_oc[2]  <= $signed({i_in_data.origin_z[31], i_in_data.origin_z})
                       - $signed({i_in_data.center_z[31], i_in_data.center_z});
            r1_dir[0] <= i_in_data.dir_x;
            r1_dir[1] <= i_in_data.dir_y;
            r1_dir[2] <= i_in_data.dir_z;
            r1_rad    <= i_in_data.sphere_radius;
        end
    end

    // stage 2: products
    logic               r2_v;
    logic signed [63:0] r2_dd [3];
    logic signed [64:0] r2_od [3];
    logic signed [65:0] r2_oo [3];
    logic        [61:0] r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_dd[i] <= r1_dir[i] * r1_dir[i];
                r2_od[i] <= r1_oc[i] * r1_dir[i];
                r2_oo[i] <= r1_oc[i] * r1_oc[i];
            end
            r2_rr <= r1_rad * r1_rad;
        end
    end

    // stage 3: sums
    logic               r3_v;
    logic        [63:0] r3_a;
    logic signed [66:0] r3_hb;
    logic signed [66:0] r3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a  <= $unsigned(r2_dd[0]) + $unsigned(r2_dd[1]) + $unsigned(r2_dd[2]);
            r3_hb <= r2_od[0] + r2_od[1] + r2_od[2];
            r3_c  <= r2_oo[0] + r2_oo[1] + r2_oo[2] - $signed({5'b0, r2_rr});
        end
    end

    // stage 4: magnitudes
    logic               r4_v;
    logic        [63:0] r4_a;
    logic               r4_azero;
    logic signed [66:0] r4_hb;
    logic        [65:0] r4_hbm;
    logic               r4_cneg;
    logic        [65:0] r4_cm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_a     <= r3_a;
            r4_azero <= (r3_a == 64'd0);
            r4_hb    <= r3_hb;
            r4_hbm   <= r3_hb[66] ? 66'(-r3_hb) : r3_hb[65:0];
            r4_cneg  <= r3_c[66];
            r4_cm    <= r3_c[66] ? 66'(-r3_c) : r3_c[65:0];
        end
    end

    // stage 5: partial products
    logic               r5_v;
    logic        [63:0] r5_a;
    logic               r5_azero;
    logic signed [66:0] r5_hb;
    logic               r5_cneg;
    logic        [65:0] r5_h00, r5_h01, r5_h11;
    logic        [65:0] r5_c00, r5_c01, r5_c10, r5_c11;
    logic        [65:0] w_a66;

    assign w_a66 = {2'b00, r4_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_a     <= r4_a;
            r5_azero <= r4_azero;
            r5_hb    <= r4_hb;
            r5_cneg  <= r4_cneg;
            r5_h00   <= r4_hbm[32:0] * r4_hbm[32:0];
            r5_h01   <= r4_hbm[32:0] * r4_hbm[65:33];
            r5_h11   <= r4_hbm[65:33] * r4_hbm[65:33];
            r5_c00   <= w_a66[32:0] * r4_cm[32:0];
            r5_c01   <= w_a66[32:0] * r4_cm[65:33];
            r5_c10   <= w_a66[65:33] * r4_cm[32:0];
            r5_c11   <= w_a66[65:33] * r4_cm[65:33];
        end
    end

    // stage 6: middle terms
    logic               r6_v;
    logic        [63:0] r6_a;
    logic               r6_azero;
    logic signed [66:0] r6_hb;
    logic               r6_cneg;
    logic        [65:0] r6_h00, r6_h11, r6_c00, r6_c11;
    logic        [66:0] r6_hmid, r6_cmid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_a     <= r5_a;
            r6_azero <= r5_azero;
            r6_hb    <= r5_hb;
            r6_cneg  <= r5_cneg;
            r6_h00   <= r5_h00;
            r6_h11   <= r5_h11;
            r6_c00   <= r5_c00;
            r6_c11   <= r5_c11;
            r6_hmid  <= {r5_h01, 1'b0};
            r6_cmid  <= 67'(r5_c01) + 67'(r5_c10);
        end
    end

    // stage 7: full products
    logic               r7_v;
    logic        [63:0] r7_a;
    logic               r7_azero;
    logic signed [66:0] r7_hb;
    logic               r7_cneg;
    logic       [131:0] r7_hsq, r7_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_a     <= r6_a;
            r7_azero <= r6_azero;
            r7_hb    <= r6_hb;
            r7_cneg  <= r6_cneg;
            r7_hsq   <= {r6_h11, r6_h00} + (132'(r6_hmid) << 33);
            r7_ac    <= {r6_c11, r6_c00} + (132'(r6_cmid) << 33);
        end
    end

    // stage 8: discriminant
    logic               r8_v;
    logic        [63:0] r8_a;
    logic               r8_azero;
    logic signed [66:0] r8_hb;
    logic       [132:0] r8_disc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_a     <= r7_a;
            r8_azero <= r7_azero;
            r8_hb    <= r7_hb;
            r8_disc  <= r7_cneg ? {1'b0, r7_hsq} + {1'b0, r7_ac}
                                : {1'b0, r7_hsq} - {1'b0, r7_ac};
        end
    end

    // square root, one root bit per stage
    logic        r_sq_v    [RSI_SQ_STEPS];
    logic [66:0] r_sq_rem  [RSI_SQ_STEPS];
    logic [65:0] r_sq_root [RSI_SQ_STEPS];
    logic [131:0] r_sq_bits [RSI_SQ_STEPS];
    t_tag        r_sq_tag  [RSI_SQ_STEPS];

    for (genvar k = 0; k < RSI_SQ_STEPS; k++) begin : g_sq
        logic        w_v;
        logic [66:0] w_rem;
        logic [65:0] w_root;
        logic [131:0] w_bits;
        t_tag        w_tag;
        logic [67:0] w_cur;
        logic [67:0] w_trial;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_v          = r8_v;
            assign w_rem        = '0;
            assign w_root       = '0;
            assign w_bits       = r8_disc[131:0];
            assign w_tag.azero  = r8_azero;
            assign w_tag.dneg   = r8_disc[132];
            assign w_tag.a      = r8_a;
            assign w_tag.hb     = r8_hb;
        end else begin : g_next
            assign w_v    = r_sq_v[k-1];
            assign w_rem  = r_sq_rem[k-1];
            assign w_root = r_sq_root[k-1];
            assign w_bits = r_sq_bits[k-1];
            assign w_tag  = r_sq_tag[k-1];
        end

        assign w_cur   = {w_rem[65:0], w_bits[131:130]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k]  <= w_ge ? 67'(w_cur - w_trial) : w_cur[66:0];
                r_sq_root[k] <= {w_root[64:0], w_ge};
                r_sq_bits[k] <= {w_bits[129:0], 2'b00};
                r_sq_tag[k]  <= w_tag;
            end
        end
    end

    // stage 9: numerator -half_b - sqrt(disc)
    logic               r9_v;
    t_tag               r9_tag;
    logic signed [67:0] r9_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (w_en) begin
            r9_v <= r_sq_v[RSI_SQ_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_tag <= r_sq_tag[RSI_SQ_STEPS-1];
            r9_num <= -68'(r_sq_tag[RSI_SQ_STEPS-1].hb)
                    - $signed({2'b00, r_sq_root[RSI_SQ_STEPS-1]});
        end
    end

    // stage 10: numerator magnitude
    logic        r10_v;
    t_tag        r10_tag;
    logic        r10_neg;
    logic [66:0] r10_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (w_en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_tag <= r9_tag;
            r10_neg <= r9_num[67];
            r10_mag <= r9_num[67] ? 67'(-r9_num) : r9_num[66:0];
        end
    end

    // stage 11: scale, overflow check, initial remainder
    logic          r11_v;
    t_dtag         r11_tag;
    logic [63:0]   r11_rem;
    logic [31:0]   r11_nlo;
    logic [NW-1:0] w_n;
    logic          w_over;

    assign w_n    = {r10_mag, {FRAC_BITS{1'b0}}};
    assign w_over = ({{(CW-NW){1'b0}}, w_n} >= {{(CW-96){1'b0}}, r10_tag.a, 32'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (w_en) begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_tag.azero <= r10_tag.azero;
            r11_tag.dneg  <= r10_tag.dneg;
            r11_tag.neg   <= r10_neg;
            r11_tag.over  <= w_over;
            r11_tag.a     <= r10_tag.a;
            r11_rem       <= 64'(w_n[NW-1:32]);
            r11_nlo       <= w_n[31:0];
        end
    end

    // restoring divide, one quotient bit per stage
    logic                     r_dv_v   [RSI_DIV_STEPS];
    logic [63:0]              r_dv_rem [RSI_DIV_STEPS];
    logic [RSI_DIV_STEPS-1:0] r_dv_q   [RSI_DIV_STEPS];
    logic [31:0]              r_dv_nlo [RSI_DIV_STEPS];
    t_dtag                    r_dv_tag [RSI_DIV_STEPS];

    for (genvar k = 0; k < RSI_DIV_STEPS; k++) begin : g_dv
        logic                     w_v;
        logic [63:0]              w_rem;
        logic [RSI_DIV_STEPS-1:0] w_q;
        logic [31:0]              w_nlo;
        t_dtag                    w_tag;
        logic [64:0]              w_t;
        logic                     w_ge;

        if (k == 0) begin : g_first
            assign w_v   = r11_v;
            assign w_rem = r11_rem;
            assign w_q   = '0;
            assign w_nlo = r11_nlo;
            assign w_tag = r11_tag;
        end else begin : g_next
            assign w_v   = r_dv_v[k-1];
            assign w_rem = r_dv_rem[k-1];
            assign w_q   = r_dv_q[k-1];
            assign w_nlo = r_dv_nlo[k-1];
            assign w_tag = r_dv_tag[k-1];
        end

        assign w_t  = {w_rem, w_nlo[31]};
        assign w_ge = (w_t >= {1'b0, w_tag.a});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k] <= w_ge ? 64'(w_t - {1'b0, w_tag.a}) : w_t[63:0];
                r_dv_q[k]   <= {w_q[RSI_DIV_STEPS-2:0], w_ge};
                r_dv_nlo[k] <= {w_nlo[30:0], 1'b0};
                r_dv_tag[k] <= w_tag;
            end
        end
    end

    // output: saturate and flag
    t_dtag       w_ftag;
    logic [31:0] w_q;
    logic [31:0] w_sat;
    logic        w_hit;

    assign w_ftag = r_dv_tag[RSI_DIV_STEPS-1];
    assign w_q    = r_dv_q[RSI_DIV_STEPS-1];
    assign w_hit  = !w_ftag.azero && !w_ftag.dneg;

    always_comb begin
        if (w_ftag.neg) begin
            w_sat = (w_ftag.over || w_q > RSI_DIST_MIN) ? RSI_DIST_MIN : 32'(-w_q);
        end else begin
            w_sat = (w_ftag.over || w_q[31]) ? RSI_DIST_MAX : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_v[RSI_DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.hit        <= w_hit;
            r_out.degenerate <= w_ftag.azero;
            r_out.distance   <= w_hit ? $signed(w_sat) : 32'sd0;
        end
    end

endmodule

@@ bench/rsi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker
// Watches both channels of ray_sphere_intersect, predicts each result from the
// accepted ray/sphere pair with exact wide arithmetic and compares in order.
// ----------------------------------------------------------------------------
module rsi_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  rsi_pkg::t_ray_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  rsi_pkg::t_ray_out i_out_data,
    output int                o_fail_count,
    output int                o_pending
);
    import rsi_pkg::*;

    t_ray_out hit_queue[$];

    function automatic t_ray_out predict_result(t_ray_in r);
        logic signed [191:0] ox, oy, oz, dx, dy, dz, rad;
        logic signed [191:0] len2, half_b, c_term, disc, num;
        logic [191:0] rem, root, bitv, trial, mag, quot;
        logic neg;
        t_ray_out res;
        res = '0;
        ox = $signed(r.origin_x) - $signed(r.center_x);
        oy = $signed(r.origin_y) - $signed(r.center_y);
        oz = $signed(r.origin_z) - $signed(r.center_z);
        dx = $signed(r.dir_x);
        dy = $signed(r.dir_y);
        dz = $signed(r.dir_z);
        rad = {161'b0, r.sphere_radius};
        len2 = dx * dx + dy * dy + dz * dz;
        half_b = ox * dx + oy * dy + oz * dz;
        c_term = ox * ox + oy * oy + oz * oz - rad * rad;
        if (len2 == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        disc = half_b * half_b - len2 * c_term;
        if (disc < 0) return res;
        rem = disc;
        root = '0;
        bitv = 192'b1 << 190;
        while (bitv != 0) begin
            trial = root + bitv;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        num = -half_b - $signed(root);
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag << RSI_FRAC_BITS;
        quot = mag / len2;
        res.hit = 1'b1;
        if (neg) res.distance = (quot > 192'h8000_0000) ? RSI_DIST_MIN : -quot[31:0];
        else     res.distance = (quot > 192'h7FFF_FFFF) ? RSI_DIST_MAX : quot[31:0];
        return res;
    endfunction

    initial o_fail_count = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_ray_out exp_res;
        int errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) hit_queue.push_front(predict_result(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (hit_queue.size() == 0) begin
                    $error("unexpected transfer on output: %p", i_out_data);
                    errs++;
                end else begin
                    exp_res = hit_queue.pop_back();
                    if (exp_res.hit !== i_out_data.hit) begin
                        $error("hit: expected %0d, actual %0d", exp_res.hit, i_out_data.hit);
                        errs++;
                    end
                    if (exp_res.degenerate !== i_out_data.degenerate) begin
                        $error("degenerate: expected %0d, actual %0d",
                               exp_res.degenerate, i_out_data.degenerate);
                        errs++;
                    end
                    if (exp_res.distance !== i_out_data.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               exp_res.distance, i_out_data.distance);
                        errs++;
                    end
                end
            end
        end
        o_pending = hit_queue.size();
        if (errs != 0) o_fail_count <= o_fail_count + errs;
    end

endmodule

@@ bench/tb_ray_sphere_intersect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect
// Drives directed and random ray/sphere pairs with random idling on both sides
// and one long output hold-off; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect;
    import rsi_pkg::*;

    localparam int NUM_RANDOM = 2000;
    localparam int CALM_AFTER = 1800;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_ray_in  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_ray_out out_data;
    int       fail_count;
    int       pending;
    int       sent = 0;
    logic     sending_done = 1'b0;

    always #5 i_clk = ~i_clk;

    ray_sphere_intersect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    rsi_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_ray_in make_ray(int o, int d, int c, int rad);
        t_ray_in r;
        r.origin_x = o;  r.origin_y = o / 2; r.origin_z = -o;
        r.dir_x = d;     r.dir_y = 0;        r.dir_z = d / 4;
        r.center_x = c;  r.center_y = 0;     r.center_z = -c;
        r.sphere_radius = 31'(rad);
        return r;
    endfunction

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    function automatic t_ray_in random_ray();
        t_ray_in r;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, 31'($urandom)};
        end else begin
            r.origin_x = near_coord(); r.origin_y = near_coord(); r.origin_z = near_coord();
            r.center_x = near_coord(); r.center_y = near_coord(); r.center_z = near_coord();
            r.dir_x = near_coord() >>> $urandom_range(0, 12);
            r.dir_y = near_coord() >>> $urandom_range(0, 12);
            r.dir_z = near_coord() >>> $urandom_range(0, 12);
            r.sphere_radius = 31'($urandom_range(0, 32'h0030_0000));
            if (kind == 9) begin
                r.dir_x = 0; r.dir_y = 0; r.dir_z = 0;
            end
        end
        return r;
    endfunction

    task automatic send(t_ray_in r);
        int gap;
        if (sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data = r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    initial begin
        int len;
        forever begin
            @(negedge i_clk);
            if (sent == 400) begin
                out_stall = 1'b1;
                repeat (400) @(negedge i_clk);
                out_stall = 1'b0;
                wait (sent != 400);
            end else if (sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 8);
                out_stall = 1'b1;
                repeat (len) @(negedge i_clk);
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    initial begin
        t_ray_in r;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        // zero direction
        send(make_ray(32'h0001_0000, 0, 0, 32'h0001_0000));
        // plain hit, ray from outside toward sphere
        r = '0; r.origin_x = -32'sh0005_0000; r.dir_x = 32'h0001_0000;
        r.sphere_radius = 31'h0001_0000; send(r);
        // miss
        r.origin_y = 32'h0005_0000; send(r);
        // root behind the origin
        r = '0; r.origin_x = 32'h0005_0000; r.dir_x = 32'h0001_0000;
        r.sphere_radius = 31'h0001_0000; send(r);
        // tangent
        r = '0; r.origin_x = -32'sh0005_0000; r.origin_y = 32'h0001_0000;
        r.dir_x = 32'h0001_0000; r.sphere_radius = 31'h0001_0000; send(r);
        // saturation high and low
        r = '0; r.origin_x = 32'sh8000_0000; r.center_x = 32'sh7FFF_FFFF; r.dir_x = 1;
        r.sphere_radius = 31'd1; send(r);
        r.dir_x = -1; send(r);
        // extremes of every field
        send('1);
        send('0);
        r = {{9{32'sh8000_0000}}, 31'h7FFF_FFFF}; send(r);
        r = {{9{32'sh7FFF_FFFF}}, 31'h7FFF_FFFF}; send(r);
        r = {{3{32'sh7FFF_FFFF}}, {3{32'sh8000_0000}}, {3{32'sh8000_0000}},
             31'h7FFF_FFFF}; send(r);
        r = {{3{32'sh8000_0000}}, {3{32'sh7FFF_FFFF}}, {3{32'sh7FFF_FFFF}},
             31'h0}; send(r);
        r = '0; r.dir_z = 32'sh8000_0000; r.sphere_radius = 31'h7FFF_FFFF; send(r);
        // origin inside sphere, radius zero
        r = '0; r.dir_y = 32'h0000_8000; r.sphere_radius = 31'h0004_0000; send(r);
        r.sphere_radius = 31'd0; send(r);
        repeat (NUM_RANDOM) send(random_ray());
        in_valid = 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        wait (sending_done);
        wait (pending == 0);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
